FILE: rtl/lhr_pkg.sv
// Shared types, constants and sizes of the latency histogram recorder.
`timescale 1ns / 1ps
package lhr_pkg;

  // Default sizes
  localparam int DefNumCounters   = 16;
  localparam int DefNumMetrics    = 8;
  localparam int DefSpikeDepth    = 8;
  localparam int DefWordsPerMetric = 12;
  localparam int DefQueueDepth    = 2;

  // Word address width covering the largest map plus the count word
  localparam int ADDR_W = 10;
  // Bin edge width: 1000 us times a cycles_per_us of 4095 fits in 22 bits
  localparam int EDGE_W = 22;
  localparam int NUM_EDGES = 8;
  localparam int SLOW_EDGE = 4;

  // Request types
  localparam logic [1:0] REQ_ADD  = 2'd0;
  localparam logic [1:0] REQ_TIME = 2'd1;
  localparam logic [1:0] REQ_DROP = 2'd2;
  localparam logic [1:0] REQ_READ = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_ENABLE = 2'd0;
  localparam logic [1:0] CFG_CPU    = 2'd1;
  localparam logic [1:0] CFG_READY  = 2'd2;

  localparam logic [31:0] MARKER_RESET = 32'hffff_fffe;
  localparam logic [31:0] MARKER_DROP  = 32'hffff_ffff;

  localparam logic [9:0] EDGE_US [NUM_EDGES] = '{
    10'd8, 10'd16, 10'd32, 10'd64, 10'd125, 10'd250, 10'd500, 10'd1000
  };

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_TIME  = 3'd1,
    OP_DROP  = 3'd2,
    OP_RMEM  = 3'd3,
    OP_RCNT  = 3'd4,
    OP_RZERO = 3'd5
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] addr;
    logic [3:0]        bin;
    logic              slow;
    logic              spike;
    logic [31:0]       value;
    logic [31:0]       id;
    logic [31:0]       gen;
    logic [31:0]       ts;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic full;
    logic pop;
    logic empty;
  } queue_ctrl_t;

endpackage

FILE: rtl/latency_histogram_recorder.sv
// Top level of the latency histogram recorder.
`timescale 1ns / 1ps
// Channel     Handshake                      Payload
// request     start_i high, busy_o low       req_type_i .. read_address_i
// result      result_valid_o, one cycle      read_data_o
// config      cfg_valid_i && cfg_ready_o     cfg_index_i, cfg_data_i
//
// The back end runs one word access per memory port cycle: an add updates a
// counter, a timing four metric words and maybe a spike entry, a drop a spike
// entry, a memory read one word. After reset a clearing pass writes every word,
// one per cycle (NUM_COUNTERS + NUM_METRICS*WORDS_PER_METRIC + 4*SPIKE_DEPTH
// words, 144 by default); busy_o is high throughout and also rises while the
// command queue is full. Results are never held off by the receiver.
module latency_histogram_recorder #(
  parameter int NUM_COUNTERS     = lhr_pkg::DefNumCounters,
  parameter int NUM_METRICS      = lhr_pkg::DefNumMetrics,
  parameter int SPIKE_DEPTH      = lhr_pkg::DefSpikeDepth,
  parameter int WORDS_PER_METRIC = lhr_pkg::DefWordsPerMetric
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  req_type_i,
  input  logic [3:0]  slot_index_i,
  input  logic [31:0] add_value_i,
  input  logic [31:0] elapsed_cycles_i,
  input  logic [31:0] event_id_i,
  input  logic [31:0] event_generation_i,
  input  logic        reset_flag_i,
  input  logic [31:0] timestamp_i,
  input  logic [7:0]  read_address_i,
  output logic        result_valid_o,
  output logic [31:0] read_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import lhr_pkg::*;

  cmd_t        front_cmd, head_cmd;
  queue_ctrl_t q_in, q_out;
  logic        push, pop, clearing;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = clearing || q_out.full;
  assign q_in.push   = push;
  assign q_in.pop    = pop;
  assign q_in.full   = 1'b0;
  assign q_in.empty  = 1'b0;

  lhr_front #(
    .NUM_COUNTERS(NUM_COUNTERS), .NUM_METRICS(NUM_METRICS),
    .SPIKE_DEPTH(SPIKE_DEPTH), .WORDS_PER_METRIC(WORDS_PER_METRIC)
  ) u_front (
    .clk_i, .rst_ni,
    .accept_i(start_i && !busy_o),
    .req_type_i, .slot_index_i, .add_value_i, .elapsed_cycles_i,
    .event_id_i, .event_generation_i, .reset_flag_i, .timestamp_i,
    .read_address_i,
    .cfg_write_i(cfg_valid_i && cfg_ready_o),
    .cfg_index_i, .cfg_data_i,
    .push_o(push), .cmd_o(front_cmd)
  );

  lhr_queue #(.DEPTH(DefQueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .ctrl_i(q_in), .ctrl_o(q_out),
    .cmd_i(front_cmd), .cmd_o(head_cmd)
  );

  lhr_back #(
    .NUM_COUNTERS(NUM_COUNTERS), .NUM_METRICS(NUM_METRICS),
    .SPIKE_DEPTH(SPIKE_DEPTH), .WORDS_PER_METRIC(WORDS_PER_METRIC)
  ) u_back (
    .clk_i, .rst_ni,
    .empty_i(q_out.empty), .cmd_i(head_cmd), .pop_o(pop),
    .clearing_o(clearing), .result_valid_o, .read_data_o
  );

endmodule

FILE: rtl/lhr_front.sv
// Front end: configuration registers, request classification and bin search.
`timescale 1ns / 1ps
module lhr_front #(
  parameter int NUM_COUNTERS     = lhr_pkg::DefNumCounters,
  parameter int NUM_METRICS      = lhr_pkg::DefNumMetrics,
  parameter int SPIKE_DEPTH      = lhr_pkg::DefSpikeDepth,
  parameter int WORDS_PER_METRIC = lhr_pkg::DefWordsPerMetric
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [1:0]         req_type_i,
  input  logic [3:0]         slot_index_i,
  input  logic [31:0]        add_value_i,
  input  logic [31:0]        elapsed_cycles_i,
  input  logic [31:0]        event_id_i,
  input  logic [31:0]        event_generation_i,
  input  logic               reset_flag_i,
  input  logic [31:0]        timestamp_i,
  input  logic [7:0]         read_address_i,
  input  logic               cfg_write_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic               push_o,
  output lhr_pkg::cmd_t      cmd_o
);
  import lhr_pkg::*;

  localparam int MetricBase = NUM_COUNTERS;
  localparam int Total = NUM_COUNTERS + NUM_METRICS * WORDS_PER_METRIC + SPIKE_DEPTH * 4;

  logic              enable_q;
  logic [2:0]        ready_q;
  logic [EDGE_W-1:0] edge_q [NUM_EDGES];
  logic [11:0]       cpu_eff;
  logic [NUM_EDGES-1:0] gt;
  logic [3:0]        bin;

  // Configuration writes; edges follow cycles_per_us, zero counts as one
  assign cpu_eff = (cfg_data_i[11:0] == 12'd0) ? 12'd1 : cfg_data_i[11:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      ready_q  <= 3'd0;
      for (int i = 0; i < NUM_EDGES; i++) begin
        edge_q[i] <= EDGE_W'(EDGE_US[i]);
      end
    end else if (cfg_write_i) begin
      case (cfg_index_i)
        CFG_ENABLE: enable_q <= cfg_data_i[0];
        CFG_CPU: begin
          for (int i = 0; i < NUM_EDGES; i++) begin
            edge_q[i] <= EDGE_W'(EDGE_US[i]) * EDGE_W'(cpu_eff);
          end
        end
        CFG_READY: ready_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Compare the sample against every edge and count the edges passed
  always_comb begin
    bin = 4'd0;
    for (int i = 0; i < NUM_EDGES; i++) begin
      gt[i] = elapsed_cycles_i > 32'(edge_q[i]);
      bin   = bin + 4'(gt[i]);
    end
  end

  // Classify the request and build the command
  always_comb begin
    push_o      = 1'b0;
    cmd_o       = '0;
    cmd_o.op    = OP_RZERO;
    cmd_o.bin   = bin;
    cmd_o.slow  = gt[SLOW_EDGE];
    cmd_o.id    = event_id_i;
    cmd_o.gen   = event_generation_i;
    cmd_o.ts    = timestamp_i;
    cmd_o.value = elapsed_cycles_i;
    case (req_type_i)
      REQ_ADD: begin
        cmd_o.op    = OP_ADD;
        cmd_o.addr  = ADDR_W'(slot_index_i);
        cmd_o.value = add_value_i;
        push_o      = accept_i && enable_q && (32'(slot_index_i) < NUM_COUNTERS);
      end
      REQ_TIME: begin
        cmd_o.op    = OP_TIME;
        cmd_o.addr  = ADDR_W'(MetricBase) +
                      ADDR_W'(slot_index_i) * ADDR_W'(WORDS_PER_METRIC);
        cmd_o.spike = gt[SLOW_EDGE] && ({1'b0, ready_q} == slot_index_i);
        push_o      = accept_i && enable_q && (32'(slot_index_i) < NUM_METRICS);
      end
      REQ_DROP: begin
        cmd_o.op    = OP_DROP;
        cmd_o.spike = 1'b1;
        cmd_o.value = reset_flag_i ? MARKER_RESET : MARKER_DROP;
        push_o      = accept_i && enable_q;
      end
      REQ_READ: begin
        cmd_o.addr = ADDR_W'(read_address_i);
        if (32'(read_address_i) < Total) begin
          cmd_o.op = OP_RMEM;
        end else if (32'(read_address_i) == Total) begin
          cmd_o.op = OP_RCNT;
        end else begin
          cmd_o.op = OP_RZERO;
        end
        push_o = accept_i;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/lhr_queue.sv
// Short command queue between the front end and the execution engine.
`timescale 1ns / 1ps
module lhr_queue #(
  parameter int DEPTH = lhr_pkg::DefQueueDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lhr_pkg::queue_ctrl_t ctrl_i,
  output lhr_pkg::queue_ctrl_t ctrl_o,
  input  lhr_pkg::cmd_t        cmd_i,
  output lhr_pkg::cmd_t        cmd_o
);
  import lhr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          entry_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign ctrl_o.full  = (cnt_q == CW'(DEPTH));
  assign ctrl_o.empty = (cnt_q == '0);
  assign ctrl_o.push  = do_push;
  assign ctrl_o.pop   = do_pop;
  assign do_push = ctrl_i.push && !ctrl_o.full;
  assign do_pop  = ctrl_i.pop && !ctrl_o.empty;
  assign cmd_o   = entry_q[rd_q];

  // Store a pushed command
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= cmd_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

FILE: rtl/lhr_back.sv
// Execution engine: word memory, read-modify-write sequencer and spike ring.
`timescale 1ns / 1ps
module lhr_back #(
  parameter int NUM_COUNTERS     = lhr_pkg::DefNumCounters,
  parameter int NUM_METRICS      = lhr_pkg::DefNumMetrics,
  parameter int SPIKE_DEPTH      = lhr_pkg::DefSpikeDepth,
  parameter int WORDS_PER_METRIC = lhr_pkg::DefWordsPerMetric
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  lhr_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          clearing_o,
  output logic          result_valid_o,
  output logic [31:0]   read_data_o
);
  import lhr_pkg::*;

  localparam int SpikeBase = NUM_COUNTERS + NUM_METRICS * WORDS_PER_METRIC;
  localparam int Total = SpikeBase + SPIKE_DEPTH * 4;
  localparam int AW = $clog2(Total);
  localparam int PW = (SPIKE_DEPTH > 1) ? $clog2(SPIKE_DEPTH) : 1;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_RD    = 6'b000100,
    S_WR    = 6'b001000,
    S_SPK   = 6'b010000,
    S_RESP  = 6'b100000
  } state_e;

  state_e        state_q, state_d;
  cmd_t          cmd_q;
  logic [1:0]    k_q, k_d;
  logic [AW-1:0] clr_q;
  logic [PW-1:0] ptr_q;
  logic [31:0]   count_q;
  logic [31:0]   mem_q [Total];
  logic [31:0]   rdata_q;
  logic [AW-1:0] raddr, waddr;
  logic [31:0]   wdata;
  logic          we;
  logic [ADDR_W-1:0] word_addr, spike_addr;
  logic [31:0]   spike_word;

  assign pop_o          = (state_q == S_IDLE) && !empty_i;
  assign clearing_o     = (state_q == S_CLEAR);
  assign result_valid_o = (state_q == S_RESP);
  assign read_data_o    = (cmd_q.op == OP_RMEM) ? rdata_q :
                          (cmd_q.op == OP_RCNT) ? count_q : 32'd0;

  // Address of the word in work and of the spike word
  always_comb begin
    word_addr = cmd_q.addr;
    if (cmd_q.op == OP_TIME) begin
      word_addr = cmd_q.addr + ((k_q == 2'd3) ? ADDR_W'(cmd_q.bin) + ADDR_W'(3)
                                              : ADDR_W'(k_q));
    end
    spike_addr = ADDR_W'(SpikeBase) + ADDR_W'({ptr_q, 2'b00}) + ADDR_W'(k_q);
    case (k_q)
      2'd0:    spike_word = cmd_q.id;
      2'd1:    spike_word = cmd_q.gen;
      2'd2:    spike_word = cmd_q.value;
      default: spike_word = cmd_q.ts;
    endcase
  end

  // Select the memory write
  always_comb begin
    raddr = word_addr[AW-1:0];
    waddr = word_addr[AW-1:0];
    we    = 1'b0;
    wdata = rdata_q + 32'd1;
    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = 32'd0;
      end
      S_WR: begin
        we = 1'b1;
        if (cmd_q.op == OP_ADD) begin
          wdata = rdata_q + cmd_q.value;
        end else begin
          case (k_q)
            2'd1:    wdata = (cmd_q.value > rdata_q) ? cmd_q.value : rdata_q;
            2'd2:    wdata = rdata_q + 32'(cmd_q.slow);
            default: wdata = rdata_q + 32'd1;
          endcase
        end
      end
      S_SPK: begin
        we    = 1'b1;
        waddr = spike_addr[AW-1:0];
        wdata = spike_word;
      end
      default: ;
    endcase
  end

  // Word memory with registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  // Sequence the words of one command
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    case (state_q)
      S_CLEAR: if (clr_q == AW'(Total - 1)) state_d = S_IDLE;
      S_IDLE: begin
        k_d = 2'd0;
        if (!empty_i) begin
          case (cmd_i.op)
            OP_ADD, OP_TIME, OP_RMEM: state_d = S_RD;
            OP_DROP:                  state_d = S_SPK;
            default:                  state_d = S_RESP;
          endcase
        end
      end
      S_RD: state_d = (cmd_q.op == OP_RMEM) ? S_RESP : S_WR;
      S_WR: begin
        if (cmd_q.op == OP_ADD) begin
          state_d = S_IDLE;
        end else if (k_q == 2'd3) begin
          k_d     = 2'd0;
          state_d = cmd_q.spike ? S_SPK : S_IDLE;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = S_RD;
        end
      end
      S_SPK: begin
        k_d = k_q + 2'd1;
        if (k_q == 2'd3) state_d = S_IDLE;
      end
      S_RESP:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
  end

  // Control registers; the ring pointer wraps at the ring depth and restarts
  // with the write count when that count wraps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      k_q     <= 2'd0;
      clr_q   <= '0;
      ptr_q   <= '0;
      count_q <= 32'd0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if ((state_q == S_SPK) && (k_q == 2'd3)) begin
        count_q <= count_q + 32'd1;
        ptr_q   <= ((ptr_q == PW'(SPIKE_DEPTH - 1)) || (count_q == 32'hffff_ffff)) ?
                   '0 : ptr_q + 1'b1;
      end
    end
  end

endmodule

FILE: rtl/lhr_checker.sv
// Port-level checks of the latency histogram recorder and their binding.
`timescale 1ns / 1ps
module lhr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        busy_o,
  input logic        result_valid_o,
  input logic [31:0] read_data_o
);

  // Hold busy while the clearing pass starts after reset
  a_busy_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> busy_o) else $error("busy low right after reset");

  // No back-to-back strobes: two results never come in consecutive cycles
  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("back-to-back results");

  // No result in the sample just out of reset, as the memory clear begins
  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !result_valid_o) else $error("result during clear");

  a_data_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !$isunknown(read_data_o)) else $error("unknown read data");

endmodule

bind latency_histogram_recorder lhr_checker u_lhr_checker (
  .clk_i, .rst_ni, .busy_o, .result_valid_o, .read_data_o
);

FILE: tb/tb_latency_histogram_recorder.sv
// Self-checking testbench of the latency histogram recorder: directed table plus random requests.
`timescale 1ns / 1ps
module tb_latency_histogram_recorder;
  import lhr_pkg::*;

  localparam int          NCnt      = 16;
  localparam int          NMet      = 8;
  localparam int          NSpk      = 8;
  localparam int          Wpm       = 12;
  localparam int          DrainWait = 60;
  localparam int          IdleLimit = 4000;
  localparam int          RandItems = 200;
  localparam logic [1:0]  CFG_NONE  = 2'd3;

  typedef struct {
    logic [1:0]  req;
    logic [3:0]  slot;
    logic [31:0] addv;
    logic [31:0] cyc;
    logic [31:0] id;
    logic [31:0] gen;
    logic        rflag;
    logic [31:0] ts;
    logic [7:0]  addr;
    bit          fixed;
    logic [31:0] want;
  } request_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  req_type_i = '0;
  logic [3:0]  slot_index_i = '0;
  logic [31:0] add_value_i = '0;
  logic [31:0] elapsed_cycles_i = '0;
  logic [31:0] event_id_i = '0;
  logic [31:0] event_generation_i = '0;
  logic        reset_flag_i = 1'b0;
  logic [31:0] timestamp_i = '0;
  logic [7:0]  read_address_i = '0;
  logic        result_valid_o;
  logic [31:0] read_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  latency_histogram_recorder u_dut (.*);

  // Shadow copy of the block state
  logic [31:0] sh_cnt [NCnt];
  logic [31:0] sh_met [NMet*Wpm];
  logic [31:0] sh_ring [NSpk*4];
  logic [31:0] sh_spk_count;
  logic [41:0] sh_edge [NUM_EDGES];
  logic        sh_enable;
  logic [11:0] sh_cpu;
  logic [2:0]  sh_ready;

  logic [31:0] read_words_due [$];
  int          errors = 0;
  int          n_reads = 0;
  int          n_sent = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void load_edges();
    logic [41:0] c;
    c = (sh_cpu == '0) ? 42'd1 : 42'(sh_cpu);
    for (int i = 0; i < NUM_EDGES; i++) sh_edge[i] = 42'(EDGE_US[i]) * c;
  endfunction

  function automatic void log_spike(input logic [31:0] w0, w1, w2, w3);
    int e;
    e = (sh_spk_count % NSpk) * 4;
    sh_spk_count++;
    sh_ring[e] = w0;
    sh_ring[e+1] = w1;
    sh_ring[e+2] = w2;
    sh_ring[e+3] = w3;
  endfunction

  function automatic logic [31:0] fetch_word(input int a);
    if (a < NCnt) return sh_cnt[a];
    a -= NCnt;
    if (a < NMet*Wpm) return sh_met[a];
    a -= NMet*Wpm;
    if (a < NSpk*4) return sh_ring[a];
    a -= NSpk*4;
    return (a == 0) ? sh_spk_count : 32'd0;
  endfunction

  // Apply one accepted request to the shadow state; return 1 when a read word is due
  function automatic bit apply_request(input request_t r, output logic [31:0] word);
    int base, bin;
    bit slow;
    word = '0;
    if (r.req == REQ_READ) begin
      word = fetch_word(int'(r.addr));
      return 1'b1;
    end
    if (!sh_enable) return 1'b0;
    case (r.req)
      REQ_ADD: begin
        sh_cnt[r.slot] += r.addv;
      end
      REQ_TIME: begin
        if (r.slot < NMet) begin
          base = int'(r.slot) * Wpm;
          slow = 42'(r.cyc) > sh_edge[SLOW_EDGE];
          bin = 0;
          sh_met[base]++;
          if (r.cyc > sh_met[base+1]) sh_met[base+1] = r.cyc;
          if (slow) sh_met[base+2]++;
          for (int i = 0; i < NUM_EDGES; i++) if (42'(r.cyc) > sh_edge[i]) bin++;
          sh_met[base+3+bin]++;
          if (r.slot[2:0] == sh_ready && r.slot < NMet && slow)
            log_spike(r.id, r.gen, r.cyc, r.ts);
        end
      end
      default: begin
        log_spike(r.id, r.gen, r.rflag ? MARKER_RESET : MARKER_DROP, r.ts);
      end
    endcase
    return 1'b0;
  endfunction

  // Present one request, hold it until transfer, then idle for a drawn gap, none during a burst
  task automatic issue_request(input request_t r);
    logic [31:0] word;
    int gap;
    req_type_i = r.req;
    slot_index_i = r.slot;
    add_value_i = r.addv;
    elapsed_cycles_i = r.cyc;
    event_id_i = r.id;
    event_generation_i = r.gen;
    reset_flag_i = r.rflag;
    timestamp_i = r.ts;
    read_address_i = r.addr;
    start_i = 1'b1;
    do @(posedge clk_i); while (busy_o);
    n_sent++;
    if (apply_request(r, word)) read_words_due.push_back(r.fixed ? r.want : word);
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 17);
      if ($urandom_range(0, 15) == 0) burst_left = 20;
    end
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Drain outstanding work, then transfer one register write
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    start_i = 1'b0;
    while (read_words_due.size() > 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
    cfg_index_i = idx;
    cfg_data_i = data;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    case (idx)
      CFG_ENABLE: sh_enable = data[0];
      CFG_CPU: begin
        sh_cpu = data[11:0];
        load_edges();
      end
      CFG_READY: sh_ready = data[2:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_elapsed();
    logic [41:0] c, v;
    c = (sh_cpu == '0) ? 42'd1 : 42'(sh_cpu);
    case ($urandom_range(0, 4))
      0: v = 42'($urandom);
      1: v = 42'($urandom_range(0, 3));
      2: v = sh_edge[$urandom_range(0, NUM_EDGES-1)] + 42'($urandom_range(0, 2)) - 42'd1;
      default: v = 42'($urandom_range(0, 2000)) * c;
    endcase
    return v[31:0];
  endfunction

  function automatic request_t make_random();
    request_t r;
    int pick;
    pick = $urandom_range(0, 9);
    r.req = (pick < 2) ? REQ_ADD : (pick < 5) ? REQ_TIME : (pick < 6) ? REQ_DROP : REQ_READ;
    r.slot = (r.req == REQ_TIME && $urandom_range(0, 5) != 0) ? 4'($urandom_range(0, NMet-1))
                                                          : 4'($urandom);
    r.addv = ($urandom_range(0, 3) == 0) ? 32'hffff_ffff - 32'($urandom_range(0, 3)) : $urandom;
    r.cyc = pick_elapsed();
    if ($urandom_range(0, 2) == 0 && r.req == REQ_TIME) r.slot = {1'b0, sh_ready};
    r.id = $urandom;
    r.gen = $urandom;
    r.rflag = 1'($urandom);
    r.ts = $urandom;
    r.addr = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 144));
    r.fixed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic request_t row(input logic [1:0] rq, input logic [3:0] sl,
                                   input logic [31:0] v, input logic [7:0] ad,
                                   input bit fx, input logic [31:0] w);
    request_t r;
    r.req = rq;
    r.slot = sl;
    r.addv = v;
    r.cyc = v;
    r.id = ~v;
    r.gen = {v[15:0], v[31:16]};
    r.rflag = v[0];
    r.ts = v ^ 32'h5a5a_a5a5;
    r.addr = ad;
    r.fixed = fx;
    r.want = w;
    return r;
  endfunction

  // Check each result against the oldest expected word; watch for a stall
  always @(posedge clk_i) begin
    logic [31:0] exp_word;
    if (rst_ni) begin
      if (result_valid_o) begin
        n_reads++;
        if (read_words_due.size() == 0) begin
          report_mismatch($sformatf("unexpected read_data %h", read_data_o));
        end else begin
          exp_word = read_words_due.pop_front();
          if (read_data_o !== exp_word)
            report_mismatch($sformatf("read_data %h, want %h", read_data_o, exp_word));
        end
      end
      if ((start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no transfer for %0d cycles", IdleLimit);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  request_t dir_off [5];
  request_t dir_on [18];

  initial begin
    sh_enable = 1'b0;
    sh_cpu = 12'd1;
    sh_ready = '0;
    sh_spk_count = '0;
    foreach (sh_cnt[i]) sh_cnt[i] = '0;
    foreach (sh_met[i]) sh_met[i] = '0;
    foreach (sh_ring[i]) sh_ring[i] = '0;
    load_edges();

    // Disabled block: updates ignored, reads answer
    dir_off = '{
      row(REQ_READ, 4'd0, 32'd0, 8'd0, 1, 32'd0),
      row(REQ_ADD, 4'd0, 32'hffff_ffff, 8'd0, 0, 32'd0),
      row(REQ_DROP, 4'd0, 32'd1, 8'd0, 0, 32'd0),
      row(REQ_READ, 4'd0, 32'd0, 8'd0, 1, 32'd0),
      row(REQ_READ, 4'd0, 32'd0, 8'd144, 1, 32'd0)
    };
    // Enabled: wrap, range, extremes, markers, bin edges, unused address
    dir_on = '{
      row(REQ_ADD, 4'd0, 32'hffff_ffff, 8'd0, 0, 32'd0),
      row(REQ_ADD, 4'd0, 32'd1, 8'd0, 0, 32'd0),
      row(REQ_READ, 4'd0, 32'd0, 8'd0, 1, 32'd0),
      row(REQ_ADD, 4'd15, 32'h8000_0001, 8'd15, 0, 32'd0),
      row(REQ_READ, 4'd0, 32'd0, 8'd15, 1, 32'h8000_0001),
      row(REQ_TIME, 4'd9, 32'd5, 8'd0, 0, 32'd0),
      row(REQ_TIME, 4'd15, 32'd5, 8'd0, 0, 32'd0),
      row(REQ_TIME, 4'd0, 32'd0, 8'd0, 0, 32'd0),
      row(REQ_TIME, 4'd0, 32'hffff_ffff, 8'd0, 0, 32'd0),
      row(REQ_READ, 4'd0, 32'd0, 8'd16, 1, 32'd2),
      row(REQ_READ, 4'd0, 32'd0, 8'd17, 1, 32'hffff_ffff),
      row(REQ_DROP, 4'd0, 32'd1, 8'd0, 0, 32'd0),
      row(REQ_DROP, 4'd0, 32'd0, 8'd0, 0, 32'd0),
      row(REQ_READ, 4'd0, 32'd0, 8'd144, 1, 32'd3),
      row(REQ_READ, 4'd0, 32'd0, 8'd118, 1, MARKER_RESET),
      row(REQ_TIME, 4'd7, 32'd8, 8'd0, 0, 32'd0),
      row(REQ_TIME, 4'd7, 32'd126, 8'd0, 0, 32'd0),
      row(REQ_READ, 4'd0, 32'd0, 8'd255, 1, 32'd0)
    };

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_off[i]) issue_request(dir_off[i]);
    write_reg(CFG_ENABLE, 32'd1);
    foreach (dir_on[i]) issue_request(dir_on[i]);
    for (int a = 16; a < 145; a++) issue_request(row(REQ_READ, 4'd0, 32'd0, 8'(a), 0, 32'd0));

    // Random phases over several settings, extremes among them
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_CPU, 32'd4095);
          write_reg(CFG_READY, 32'd7);
        end
        1: write_reg(CFG_ENABLE, 32'd0);
        2: begin
          write_reg(CFG_ENABLE, 32'd1);
          write_reg(CFG_CPU, 32'd0);
          write_reg(CFG_READY, 32'd3);
          write_reg(CFG_NONE, 32'hffff_ffff);
        end
        3: begin
          write_reg(CFG_CPU, 32'($urandom_range(1, 20)));
          write_reg(CFG_READY, 32'($urandom_range(0, 7)));
        end
        default: begin
          write_reg(CFG_CPU, 32'd1);
          write_reg(CFG_READY, 32'd0);
        end
      endcase
      repeat (RandItems) issue_request(make_random());
    end

    start_i = 1'b0;
    while (read_words_due.size() > 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);

    $display("Covered %0d requests over disabled, zero, minimum and maximum clock-rate settings;",
             n_sent);
    $display("%0d read words checked, %0d mismatches.", n_reads, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
